>>> rtl/double_hash_table_assert.svh
// Assertion macros used by the hash table top level.
`ifndef DOUBLE_HASH_TABLE_ASSERT_SVH
`define DOUBLE_HASH_TABLE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define DHT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high.
`define DHT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/dht_pkg.sv
// Types, constants and helper functions for the double-hashing key/value table.
package dht_pkg;

  localparam int TABLE_SIZE = 31;
  localparam int IDX_W      = $clog2(TABLE_SIZE);

  localparam int MODE_W   = 2;
  localparam int KEY_W    = 31;
  localparam int VAL_W    = 32;
  localparam int STATUS_W = 2;
  localparam int ENTRY_W  = KEY_W + VAL_W;

  localparam int IN_DATA_W  = ((KEY_W + VAL_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((VAL_W + 7) / 8) * 8;

  // Key is reduced DIGIT_W (4) bits per cycle, most significant digit first.
  localparam int DIGIT_W     = 4;
  localparam int KEY_DIGITS  = (KEY_W + DIGIT_W - 1) / DIGIT_W;
  localparam int KEY_PAD_W   = KEY_DIGITS * DIGIT_W;
  localparam int DIGIT_CNT_W = (KEY_DIGITS > 1) ? $clog2(KEY_DIGITS) : 1;

  typedef logic [IDX_W-1:0]   idx_t;
  typedef logic [KEY_W-1:0]   key_t;
  typedef logic [VAL_W-1:0]   val_t;
  typedef logic [IDX_W:0]     idx_ext_t;

  localparam idx_ext_t SIZE_EXT   = idx_ext_t'(TABLE_SIZE);
  localparam idx_ext_t SIZE_M1    = idx_ext_t'(TABLE_SIZE - 1);
  localparam idx_t     LAST_PROBE = idx_t'(TABLE_SIZE - 1);

  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SEARCH = 2'd1;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

  // Hash unit result towards the probe controller.
  typedef struct packed {
    logic done;
    idx_t base;
    idx_t step;
  } hash_res_t;

  // (2*r + b) mod m, with r < m.
  function automatic idx_t mod_shift(input idx_t r, input logic b, input idx_ext_t m);
    idx_ext_t t;
    t = {r, b};
    if (t >= m) t = t - m;
    return t[IDX_W-1:0];
  endfunction

  // (s + d) mod TABLE_SIZE, with s, d < TABLE_SIZE.
  function automatic idx_t slot_add(input idx_t s, input idx_t d);
    idx_ext_t t;
    t = idx_ext_t'(s) + idx_ext_t'(d);
    if (t >= SIZE_EXT) t = t - SIZE_EXT;
    return t[IDX_W-1:0];
  endfunction

endpackage

>>> rtl/dht_ram.sv
// Simple dual-port synchronous RAM with registered read.
module dht_ram #(
  parameter int DEPTH  = 31,
  parameter int WIDTH  = 63,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/dht_hash.sv
// Digit-serial reduction of a key to its base slot and probe stride.
module dht_hash (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  dht_pkg::key_t     key,
  output dht_pkg::hash_res_t res
);

  logic                                busy;
  logic                                done;
  logic [dht_pkg::DIGIT_CNT_W-1:0]     cnt;
  logic [dht_pkg::KEY_PAD_W-1:0]       shreg;
  dht_pkg::idx_t                       rem_base;
  dht_pkg::idx_t                       rem_step;
  dht_pkg::idx_t                       rem_base_next;
  dht_pkg::idx_t                       rem_step_next;

  // One digit per cycle while busy: a chain of DIGIT_W shift-and-reduce steps for each modulus.
  always_comb begin
    rem_base_next = rem_base;
    rem_step_next = rem_step;
    for (int b = 0; b < dht_pkg::DIGIT_W; b++) begin
      rem_base_next = dht_pkg::mod_shift(rem_base_next,
                        shreg[dht_pkg::KEY_PAD_W-1-b], dht_pkg::SIZE_EXT);
      rem_step_next = dht_pkg::mod_shift(rem_step_next,
                        shreg[dht_pkg::KEY_PAD_W-1-b], dht_pkg::SIZE_M1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        cnt      <= '0;
        shreg    <= dht_pkg::KEY_PAD_W'(key);
        rem_base <= '0;
        rem_step <= '0;
      end else if (busy) begin
        rem_base <= rem_base_next;
        rem_step <= rem_step_next;
        shreg    <= shreg << dht_pkg::DIGIT_W;
        cnt      <= cnt + 1'b1;
        if (cnt == dht_pkg::DIGIT_CNT_W'(dht_pkg::KEY_DIGITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign res.done = done;
  assign res.base = rem_base;
  assign res.step = rem_step + 1'b1;

endmodule

>>> rtl/double_hash_table.sv
// Top level: request handshake, probe controller, used bits and slot RAM.
//
// Open-addressing key/value table of dht_pkg::TABLE_SIZE slots with double hashing.
// One request is handled at a time. After acceptance the digit-serial hash unit reduces
// the key to its base slot and stride in KEY_DIGITS (8) digit steps, and the result is
// handed over to the probe controller. The S_FIRST state then primes the RAM read, and
// the slot RAM, with its single read port, is read one probe per cycle. A request takes
// p probes, where p runs from 1 to TABLE_SIZE. The next request is taken once the result
// has been loaded into the output register. An unused mode skips the hash and the walk
// and goes straight to S_RESPOND. The result sits in an output register, so a stalled
// result does not hold off acceptance of the next request. A second result waits while
// the first is still held by the receiver.
// Slot used bits are flip-flops cleared by reset; no clearing pass is needed.
`include "double_hash_table_assert.svh"

module double_hash_table (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [dht_pkg::IN_DATA_W-1:0]    s_tdata,   // key[30:0], value[62:31], zero pad
  input  logic [dht_pkg::MODE_W-1:0]       s_tuser,   // mode[1:0]
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [dht_pkg::OUT_DATA_W-1:0]   m_tdata,   // found_value[31:0]
  output logic [dht_pkg::STATUS_W-1:0]     m_tuser    // status[1:0]
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_HASH,
    S_FIRST,
    S_PROBE,
    S_RESPOND
  } state_t;

  state_t                          state;
  logic [dht_pkg::MODE_W-1:0]      op_mode;
  dht_pkg::key_t                   op_key;
  dht_pkg::val_t                   op_value;
  dht_pkg::idx_t                   slot;
  dht_pkg::idx_t                   stride;
  dht_pkg::idx_t                   probe_cnt;
  logic [dht_pkg::TABLE_SIZE-1:0]  used;
  logic [dht_pkg::STATUS_W-1:0]    res_status;
  dht_pkg::val_t                   res_value;
  logic [dht_pkg::STATUS_W-1:0]    out_status;
  dht_pkg::val_t                   out_value;

  dht_pkg::hash_res_t              hres;
  logic                            hash_start;
  logic                            accept;
  logic                            mode_ok;
  logic                            out_load;

  logic                            ram_we;
  dht_pkg::idx_t                   ram_raddr;
  logic [dht_pkg::ENTRY_W-1:0]     ram_rdata;
  dht_pkg::key_t                   rd_key;
  dht_pkg::val_t                   rd_value;
  dht_pkg::idx_t                   slot_next;
  logic                            slot_used;
  logic                            key_match;
  logic                            last_probe;
  logic                            ins_take;
  logic                            hit;

  assign s_tready   = (state == S_IDLE);
  assign accept     = s_tvalid && s_tready;
  assign mode_ok    = (s_tuser == dht_pkg::MODE_INSERT) || (s_tuser == dht_pkg::MODE_SEARCH) ||
                      (s_tuser == dht_pkg::MODE_REMOVE);
  assign hash_start = accept && mode_ok;
  assign out_load   = (state == S_RESPOND) && (!m_tvalid || m_tready);

  dht_hash u_hash (
    .clk   (clk),
    .rst   (rst),
    .start (hash_start),
    .key   (s_tdata[dht_pkg::KEY_W-1:0]),
    .res   (hres)
  );

  assign rd_key     = ram_rdata[dht_pkg::ENTRY_W-1 -: dht_pkg::KEY_W];
  assign rd_value   = ram_rdata[dht_pkg::VAL_W-1:0];
  assign slot_next  = dht_pkg::slot_add(slot, stride);
  assign slot_used  = used[slot];
  assign key_match  = (rd_key == op_key);
  assign last_probe = (probe_cnt == dht_pkg::LAST_PROBE);
  assign ins_take   = !slot_used || key_match;
  assign hit        = slot_used && key_match;

  // While probing, the next address is issued in the same cycle the current word arrives.
  assign ram_raddr = (state == S_PROBE) ? slot_next : slot;
  assign ram_we    = (state == S_PROBE) && (op_mode == dht_pkg::MODE_INSERT) && ins_take;

  // Writes only end a request, so a read of the same slot never overlaps one.
  dht_ram #(
    .DEPTH  (dht_pkg::TABLE_SIZE),
    .WIDTH  (dht_pkg::ENTRY_W),
    .ADDR_W (dht_pkg::IDX_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot),
    .wdata ({op_key, op_value}),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      used     <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            op_mode  <= s_tuser;
            op_key   <= s_tdata[dht_pkg::KEY_W-1:0];
            op_value <= s_tdata[dht_pkg::KEY_W +: dht_pkg::VAL_W];
            if (mode_ok) begin
              state <= S_HASH;
            end else begin
              res_status <= dht_pkg::ST_NOT_FOUND;
              res_value  <= '0;
              state      <= S_RESPOND;
            end
          end
        end
        S_HASH: begin
          if (hres.done) begin
            slot      <= hres.base;
            stride    <= hres.step;
            probe_cnt <= '0;
            state     <= S_FIRST;
          end
        end
        S_FIRST: begin
          state <= S_PROBE;
        end
        S_PROBE: begin
          res_value <= (hit && (op_mode == dht_pkg::MODE_SEARCH)) ? rd_value : '0;
          if (op_mode == dht_pkg::MODE_INSERT) begin
            if (ins_take) begin
              used[slot] <= 1'b1;
              res_status <= dht_pkg::ST_OK;
              state      <= S_RESPOND;
            end else if (last_probe) begin
              res_status <= dht_pkg::ST_FULL;
              state      <= S_RESPOND;
            end else begin
              slot      <= slot_next;
              probe_cnt <= probe_cnt + 1'b1;
            end
          end else begin
            if (hit) begin
              res_status <= dht_pkg::ST_OK;
              if (op_mode == dht_pkg::MODE_REMOVE) begin
                used[slot] <= 1'b0;
              end
              state <= S_RESPOND;
            end else if (last_probe) begin
              res_status <= dht_pkg::ST_NOT_FOUND;
              state      <= S_RESPOND;
            end else begin
              slot      <= slot_next;
              probe_cnt <= probe_cnt + 1'b1;
            end
          end
        end
        S_RESPOND: begin
          if (out_load) begin
            out_status <= res_status;
            out_value  <= res_value;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign m_tdata = dht_pkg::OUT_DATA_W'(out_value);
  assign m_tuser = out_status;

  `DHT_ASSERT_NOW(a_write_on_insert, ram_we, (state == S_PROBE) && (op_mode == dht_pkg::MODE_INSERT), "slot write outside an insert probe")
  `DHT_ASSERT_NOW(a_slot_in_range, (state == S_PROBE), (dht_pkg::idx_ext_t'(slot) < dht_pkg::SIZE_EXT) && (dht_pkg::idx_ext_t'(stride) < dht_pkg::SIZE_EXT), "probe slot or stride out of range")
  `DHT_ASSERT_NEXT(a_one_at_a_time, accept, !s_tready, "request accepted while another is in flight")
  `DHT_ASSERT_NEXT(a_probe_ends, (state == S_PROBE) && last_probe, (state == S_RESPOND), "probe walk ran past the table size")

endmodule

>>> test/tb_double_hash_table.sv
// Self-checking testbench for the double-hashing key/value table.
module tb_double_hash_table;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [dht_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam dht_pkg::key_t KEY_MAX = {dht_pkg::KEY_W{1'b1}};
  localparam dht_pkg::val_t VAL_MAX = {dht_pkg::VAL_W{1'b1}};
  // Both keys have home slot 5, so the second one lands further along.
  localparam dht_pkg::key_t STALE_KEY  = dht_pkg::key_t'(5);
  localparam dht_pkg::key_t SHADOW_KEY = dht_pkg::key_t'(36);
  localparam int RANDOM_PER_PHASE = 220;
  localparam int DRAIN_LIMIT      = 100000;
  localparam int MAX_PRINTED      = 40;

  typedef logic [dht_pkg::MODE_W-1:0] mode_t;

  typedef struct packed {
    logic [dht_pkg::STATUS_W-1:0] status;
    dht_pkg::val_t                found_value;
  } table_result_t;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            s_tvalid = 1'b0;
  logic                            s_tready;
  logic [dht_pkg::IN_DATA_W-1:0]   s_tdata = '0;   // key[30:0], value[62:31], zero pad
  logic [dht_pkg::MODE_W-1:0]      s_tuser = '0;   // mode[1:0]
  logic                            m_tvalid;
  logic                            m_tready = 1'b0;
  logic [dht_pkg::OUT_DATA_W-1:0]  m_tdata;        // found_value[31:0]
  logic [dht_pkg::STATUS_W-1:0]    m_tuser;        // status[1:0]

  // Shadow copy of the table contents
  dht_pkg::key_t slot_key  [dht_pkg::TABLE_SIZE];
  dht_pkg::val_t slot_val  [dht_pkg::TABLE_SIZE];
  logic          slot_used [dht_pkg::TABLE_SIZE];

  table_result_t pending_results[$];
  dht_pkg::key_t key_pool[$];
  int            error_count = 0;
  int            send_idle_pct = 22;
  int            recv_idle_pct = 67;

  double_hash_table i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic report_mismatch(input string msg);
    if (error_count < MAX_PRINTED) begin
      $display("ERROR @%0t: %s", $realtime, msg);
    end
    error_count++;
  endtask

  function automatic dht_pkg::idx_t probe_index(input dht_pkg::key_t key, input int unsigned i);
    int unsigned home;
    int unsigned stride;
    home   = int'(key) % dht_pkg::TABLE_SIZE;
    stride = 1 + int'(key) % (dht_pkg::TABLE_SIZE - 1);
    return dht_pkg::idx_t'((home + i * stride) % dht_pkg::TABLE_SIZE);
  endfunction

  // Applies one request to the shadow table and returns the outcome.
  function automatic table_result_t predict_outcome(input mode_t mode, input dht_pkg::key_t key,
                                                    input dht_pkg::val_t value);
    table_result_t res;
    dht_pkg::idx_t s;
    logic          done;
    res.status      = dht_pkg::ST_NOT_FOUND;
    res.found_value = '0;
    done            = 1'b0;
    if (mode == dht_pkg::MODE_INSERT) begin
      res.status = dht_pkg::ST_FULL;
      for (int i = 0; i < dht_pkg::TABLE_SIZE && !done; i++) begin
        s = probe_index(key, i);
        if (!slot_used[s] || slot_key[s] == key) begin
          slot_used[s] = 1'b1;
          slot_key[s]  = key;
          slot_val[s]  = value;
          res.status   = dht_pkg::ST_OK;
          done         = 1'b1;
        end
      end
    end else if (mode == dht_pkg::MODE_SEARCH || mode == dht_pkg::MODE_REMOVE) begin
      for (int i = 0; i < dht_pkg::TABLE_SIZE && !done; i++) begin
        s = probe_index(key, i);
        if (slot_used[s] && slot_key[s] == key) begin
          done       = 1'b1;
          res.status = dht_pkg::ST_OK;
          if (mode == dht_pkg::MODE_SEARCH) begin
            res.found_value = slot_val[s];
          end else begin
            slot_used[s] = 1'b0;
          end
        end
      end
    end
    return res;
  endfunction

  // Called on a rising edge; returns on the edge at which the request is taken.
  task automatic issue_request(input mode_t mode, input dht_pkg::key_t key,
                               input dht_pkg::val_t value);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= dht_pkg::IN_DATA_W'({value, key});
    s_tuser  <= mode;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_results.insert(pending_results.size(), predict_outcome(mode, key, value));
  endtask

  task automatic pause_until_idle();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    table_result_t exp_res;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result status=%0d value=%h",
                                  m_tuser, m_tdata));
      end else begin
        exp_res = pending_results.pop_front();
        if (m_tuser !== exp_res.status) begin
          report_mismatch($sformatf("status %0d, expected %0d", m_tuser, exp_res.status));
        end
        if (m_tdata !== dht_pkg::OUT_DATA_W'(exp_res.found_value)) begin
          report_mismatch($sformatf("found_value %h, expected %h",
                                    m_tdata, exp_res.found_value));
        end
      end
    end
  end

  task automatic test_basic_ops();
    issue_request(dht_pkg::MODE_SEARCH, '0, '0);
    issue_request(dht_pkg::MODE_REMOVE, '0, VAL_MAX);
    issue_request(dht_pkg::MODE_INSERT, '0, '0);
    issue_request(dht_pkg::MODE_INSERT, KEY_MAX, VAL_MAX);
    issue_request(dht_pkg::MODE_SEARCH, '0, VAL_MAX);
    issue_request(dht_pkg::MODE_SEARCH, KEY_MAX, '0);
    issue_request(dht_pkg::MODE_INSERT, KEY_MAX, 32'h5555_AAAA);
    issue_request(dht_pkg::MODE_SEARCH, KEY_MAX, '0);
    issue_request(MODE_UNUSED, '0, VAL_MAX);
    issue_request(MODE_UNUSED, KEY_MAX, VAL_MAX);
    issue_request(dht_pkg::MODE_REMOVE, '0, '0);
    issue_request(dht_pkg::MODE_SEARCH, '0, '0);
    issue_request(dht_pkg::MODE_REMOVE, '0, '0);
    issue_request(dht_pkg::MODE_REMOVE, KEY_MAX, '0);
  endtask

  // A fresh insert stops at the first hole, leaving an older copy further along.
  task automatic test_stale_copy();
    issue_request(dht_pkg::MODE_INSERT, SHADOW_KEY, 32'h1111_1111);
    issue_request(dht_pkg::MODE_INSERT, STALE_KEY, 32'h2222_2222);
    issue_request(dht_pkg::MODE_REMOVE, SHADOW_KEY, '0);
    issue_request(dht_pkg::MODE_INSERT, STALE_KEY, 32'h3333_3333);
    issue_request(dht_pkg::MODE_SEARCH, STALE_KEY, '0);
    issue_request(dht_pkg::MODE_REMOVE, STALE_KEY, '0);
    issue_request(dht_pkg::MODE_SEARCH, STALE_KEY, '0);
    issue_request(dht_pkg::MODE_REMOVE, STALE_KEY, '0);
    issue_request(dht_pkg::MODE_SEARCH, STALE_KEY, '0);
  endtask

  task automatic test_table_full();
    dht_pkg::key_t fill_keys[$];
    bit            seen[dht_pkg::key_t];
    dht_pkg::key_t k;
    while (fill_keys.size() < dht_pkg::TABLE_SIZE) begin
      k = dht_pkg::key_t'($urandom());
      if (!seen.exists(k)) begin
        seen[k] = 1'b1;
        fill_keys.insert(fill_keys.size(), k);
      end
    end
    foreach (fill_keys[i]) issue_request(dht_pkg::MODE_INSERT, fill_keys[i], $urandom());
    do k = dht_pkg::key_t'($urandom()); while (seen.exists(k));
    issue_request(dht_pkg::MODE_INSERT, k, $urandom());
    issue_request(dht_pkg::MODE_SEARCH, k, '0);
    issue_request(dht_pkg::MODE_INSERT, fill_keys[dht_pkg::TABLE_SIZE-1], $urandom());
    issue_request(dht_pkg::MODE_SEARCH, fill_keys[dht_pkg::TABLE_SIZE-1], '0);
    issue_request(dht_pkg::MODE_SEARCH, fill_keys[0], '0);
    pause_until_idle();
    foreach (fill_keys[i]) issue_request(dht_pkg::MODE_REMOVE, fill_keys[i], $urandom());
  endtask

  task automatic test_random_mix(input int count);
    int            r;
    mode_t         mode;
    dht_pkg::key_t key;
    dht_pkg::val_t value;
    if (key_pool.size() == 0) begin
      // small keys crowd the same home slots; wide ones toggle the high bits
      repeat (16) key_pool.insert(key_pool.size(), dht_pkg::key_t'($urandom_range(63)));
      repeat (32) key_pool.insert(key_pool.size(), dht_pkg::key_t'($urandom()));
    end
    repeat (count) begin
      r = $urandom_range(99);
      if (r < 40)      mode = dht_pkg::MODE_INSERT;
      else if (r < 72) mode = dht_pkg::MODE_SEARCH;
      else if (r < 94) mode = dht_pkg::MODE_REMOVE;
      else             mode = MODE_UNUSED;
      if ($urandom_range(9) == 0) key = dht_pkg::key_t'($urandom());
      else key = key_pool[$urandom_range(key_pool.size() - 1)];
      r = $urandom_range(9);
      if (r == 0)      value = '0;
      else if (r == 1) value = VAL_MAX;
      else             value = $urandom();
      issue_request(mode, key, value);
      if ($urandom_range(49) == 0) pause_until_idle();
    end
  endtask

  initial begin
    int waited;
    foreach (slot_used[i]) begin
      slot_used[i] = 1'b0;
      slot_key[i]  = '0;
      slot_val[i]  = '0;
    end
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_basic_ops();
    test_stale_copy();
    test_table_full();
    test_random_mix(RANDOM_PER_PHASE);
    pause_until_idle();

    send_idle_pct = 67;
    recv_idle_pct = 22;
    test_random_mix(RANDOM_PER_PHASE);
    pause_until_idle();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_mix(RANDOM_PER_PHASE);
    s_tvalid <= 1'b0;

    waited = 0;
    while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (60) @(posedge clk);
    if (pending_results.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
    end

    if (error_count == 0) begin
      $display("tb_double_hash_table: clean");
    end else begin
      $display("tb_double_hash_table: errors");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("tb_double_hash_table: errors");
    $finish;
  end

endmodule
